// File: src/fep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_pkg
// Types and constants shared by the framed event parser modules.
// ----------------------------------------------------------------------------
package fep_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN = 7;
   localparam int unsigned POS_W     = 3;

   // register map (index = paddr[4:2])
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_START     = 3'd0;
   localparam logic [2:0] REG_BUTTON    = 3'd1;
   localparam logic [2:0] REG_ENCODER   = 3'd2;
   localparam logic [2:0] REG_PITCH     = 3'd3;
   localparam logic [2:0] REG_HEARTBEAT = 3'd4;

   // register reset values
   localparam logic [7:0] START_RST     = 8'd170;
   localparam logic [7:0] BUTTON_RST    = 8'd1;
   localparam logic [7:0] ENCODER_RST   = 8'd2;
   localparam logic [7:0] PITCH_RST     = 8'd3;
   localparam logic [7:0] HEARTBEAT_RST = 8'd4;

   // event kinds on the result channel
   localparam logic [2:0] KIND_BUTTON    = 3'd0;
   localparam logic [2:0] KIND_JOG       = 3'd1;
   localparam logic [2:0] KIND_BROWSE    = 3'd2;
   localparam logic [2:0] KIND_PITCH     = 3'd3;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd4;

   // encoder ids
   localparam logic [7:0] ENC_ID_JOG    = 8'd0;
   localparam logic [7:0] ENC_ID_BROWSE = 8'd1;

   // frame class decided by the front end
   typedef enum logic [1:0] {
      CLS_BUTTON,
      CLS_ENCODER,
      CLS_PITCH,
      CLS_HEARTBEAT
   } frame_class_type;

   // configuration seen by the front end
   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] button_code;
      logic [7:0] encoder_code;
      logic [7:0] pitch_code;
      logic [7:0] heartbeat_code;
   } cfg_type;

   // one checked frame between front and back
   typedef struct packed {
      frame_class_type  frame_class;
      logic [7:0]       control_id;
      logic [15:0]      control_value;
      logic [7:0]       sequence_tag;
   } frame_type;

   // queue status toward both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// File: src/fep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_front
// Collects bytes into frames, runs the xor check and classifies the type.
// ----------------------------------------------------------------------------
module fep_front
   import fep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_take,
   input  logic [7:0] rx_byte,
   output logic       push,
   output frame_type  push_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       type_ff, id_ff, vlo_ff, vhi_ff, seq_ff;
   logic             known;
   frame_class_type  cls;

   // byte position and running check
   always_comb begin
      pos_in = pos_ff;
      xor_in = xor_ff;
      if (byte_take) begin
         if (pos_ff == '0) begin
            xor_in = '0;
            if (rx_byte == cfg.start_code) begin
               pos_in = POS_W'(1);
            end
         end else if (pos_ff < POS_W'(FRAME_LEN - 1)) begin
            xor_in = xor_ff ^ rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         xor_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
   end

   // frame body bytes, no reset needed
   always_ff @(posedge clock) begin
      if (byte_take) begin
         case (pos_ff)
            POS_W'(1): type_ff <= rx_byte;
            POS_W'(2): id_ff   <= rx_byte;
            POS_W'(3): vlo_ff  <= rx_byte;
            POS_W'(4): vhi_ff  <= rx_byte;
            POS_W'(5): seq_ff  <= rx_byte;
            default: ;
         endcase
      end
   end

   // type classification, first match wins
   always_comb begin
      known = 1'b1;
      cls   = CLS_BUTTON;
      if (type_ff == cfg.button_code) begin
         cls = CLS_BUTTON;
      end else if (type_ff == cfg.encoder_code) begin
         cls = CLS_ENCODER;
      end else if (type_ff == cfg.pitch_code) begin
         cls = CLS_PITCH;
      end else if (type_ff == cfg.heartbeat_code) begin
         cls = CLS_HEARTBEAT;
      end else begin
         known = 1'b0;
      end
   end

   // check byte closes the frame
   assign push = byte_take && (pos_ff == POS_W'(FRAME_LEN - 1)) &&
                 (xor_ff == rx_byte) && known;

   always_comb begin
      push_data.frame_class   = cls;
      push_data.control_id    = id_ff;
      push_data.control_value = {vhi_ff, vlo_ff};
      push_data.sequence_tag  = seq_ff;
   end

endmodule

// File: src/fep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_queue
// Short frame queue that decouples the front end from the result stage.
// ----------------------------------------------------------------------------
module fep_queue
   import fep_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  frame_type  push_data,
   input  logic       pop,
   output frame_type  pop_data,
   output q_stat_type stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   frame_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

// File: src/fep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_back
// Maps queued frames to events and holds the result register.
// ----------------------------------------------------------------------------
module fep_back
   import fep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  frame_type          q_data,
   input  q_stat_type         q_stat,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_kind,
   output logic [7:0]         rsp_control_id,
   output logic signed [15:0] rsp_control_value,
   output logic [7:0]         rsp_sequence_tag
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff;
   logic [7:0]  id_ff;
   logic [15:0] value_ff;
   logic [7:0]  seq_ff;
   logic [2:0]  kind;
   logic        keep;
   logic        load;

   // event kind for the head frame
   always_comb begin
      keep = 1'b1;
      kind = KIND_BUTTON;
      case (q_data.frame_class)
         CLS_BUTTON:    kind = KIND_BUTTON;
         CLS_ENCODER: begin
            if (q_data.control_id == ENC_ID_JOG) begin
               kind = KIND_JOG;
            end else if (q_data.control_id == ENC_ID_BROWSE) begin
               kind = KIND_BROWSE;
            end else begin
               keep = 1'b0;
            end
         end
         CLS_PITCH:     kind = KIND_PITCH;
         CLS_HEARTBEAT: kind = KIND_HEARTBEAT;
         default:       keep = 1'b0;
      endcase
   end

   // pop when the result register is free or being taken this cycle
   assign load  = !valid_ff || !rsp_stall;
   assign q_pop = load && !q_stat.empty;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = q_pop && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop && keep) begin
         kind_ff  <= kind;
         id_ff    <= q_data.control_id;
         value_ff <= q_data.control_value;
         seq_ff   <= q_data.sequence_tag;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_control_id    = id_ff;
   assign rsp_control_value = $signed(value_ff);
   assign rsp_sequence_tag  = seq_ff;

endmodule

// File: src/framed_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_event_parser
// Start-byte frame parser with xor check that turns control frames into events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per beat (valid/stall handshake).
//   rsp_* carries one event per good frame: kind, id, signed value, sequence.
//   psel/penable/pwrite/paddr/pwdata set the start and type codes; write them
//   only while no frame is in flight.
// Throughput: one byte per cycle sustained. The front end takes a byte in
//   every cycle the frame queue has room; the queue lets the result stage
//   stall without stopping the byte stream until QUEUE_DEPTH frames wait.
// Event path: a good frame enters the queue as its check byte is taken and
//   moves into the result register when the result stage pops it.
// Reset: synchronous; clears the frame position, the queue, the result valid
//   and loads the default codes. No clearing pass is needed.
// Receiver stall: the result holds steady; frames pile up in the queue and
//   req_stall rises once it is full.
// Bad checks, unknown types and unknown encoder ids give no event.
// ----------------------------------------------------------------------------
module framed_event_parser
   import fep_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   // event output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_event_kind,
   output logic [7:0]            rsp_control_id,
   output logic signed [15:0]    rsp_control_value,
   output logic [7:0]            rsp_sequence_tag,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;
   logic [7:0] rd_byte;
   logic       byte_take;
   logic       q_push;
   logic       q_pop;
   frame_type  q_wr_data;
   frame_type  q_rd_data;
   q_stat_type q_stat;

   // register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code     <= START_RST;
         cfg_ff.button_code    <= BUTTON_RST;
         cfg_ff.encoder_code   <= ENCODER_RST;
         cfg_ff.pitch_code     <= PITCH_RST;
         cfg_ff.heartbeat_code <= HEARTBEAT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_START:     cfg_ff.start_code     <= pwdata[7:0];
            REG_BUTTON:    cfg_ff.button_code    <= pwdata[7:0];
            REG_ENCODER:   cfg_ff.encoder_code   <= pwdata[7:0];
            REG_PITCH:     cfg_ff.pitch_code     <= pwdata[7:0];
            REG_HEARTBEAT: cfg_ff.heartbeat_code <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_START:     rd_byte = cfg_ff.start_code;
         REG_BUTTON:    rd_byte = cfg_ff.button_code;
         REG_ENCODER:   rd_byte = cfg_ff.encoder_code;
         REG_PITCH:     rd_byte = cfg_ff.pitch_code;
         REG_HEARTBEAT: rd_byte = cfg_ff.heartbeat_code;
         default:       rd_byte = '0;
      endcase
   end
   assign prdata = {24'd0, rd_byte};

   // input beat handshake
   assign req_stall = q_stat.full;
   assign byte_take = req_valid && !req_stall;

   fep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .push      (q_push),
      .push_data (q_wr_data)
   );

   fep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .stat      (q_stat)
   );

   fep_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (q_rd_data),
      .q_stat            (q_stat),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_control_id    (rsp_control_id),
      .rsp_control_value (rsp_control_value),
      .rsp_sequence_tag  (rsp_sequence_tag)
   );

`ifndef ASSERT_OFF
   // no frame is pushed into a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("frame pushed into full queue");

   // the result stage never pops an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // a pop while the result is stalled would lose an event
   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while result stalled");

   // only defined event kinds leave the block
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind <= KIND_HEARTBEAT))
      else $error("undefined event kind");
`endif

endmodule
